// File: sv/e2q_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// e2q_pkg
// Shared widths, types and the arctangent table for the Euler-to-quaternion
// datapath.
// ---------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int OUT_BITS     = 16;
    localparam int CORDIC_STEPS = 32;
    // rotator angle and vector width, headroom over the 2^31 half-angle range
    localparam int Z_BITS       = 34;
    // cosine and sine in Q30
    localparam int C_BITS       = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

    localparam logic signed [Z_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [Z_BITS-1:0] roll;
        logic signed [Z_BITS-1:0] pitch;
        logic signed [Z_BITS-1:0] yaw;
    } half_angles_t;

    typedef struct packed {
        logic signed [C_BITS-1:0] cos_r;
        logic signed [C_BITS-1:0] sin_r;
        logic signed [C_BITS-1:0] cos_p;
        logic signed [C_BITS-1:0] sin_p;
        logic signed [C_BITS-1:0] cos_y;
        logic signed [C_BITS-1:0] sin_y;
    } trig_t;

    // arctan(2^-i), 2^32 units per pi
    function automatic logic signed [Z_BITS-1:0] atan_entry(input int idx);
        logic signed [Z_BITS-1:0] v;
        unique case (idx)
            0:  v = 34'sd1073741824;
            1:  v = 34'sd633866811;
            2:  v = 34'sd334917815;
            3:  v = 34'sd170009512;
            4:  v = 34'sd85334662;
            5:  v = 34'sd42708931;
            6:  v = 34'sd21359677;
            7:  v = 34'sd10680490;
            8:  v = 34'sd5340327;
            9:  v = 34'sd2670173;
            10: v = 34'sd1335088;
            11: v = 34'sd667544;
            12: v = 34'sd333772;
            13: v = 34'sd166886;
            14: v = 34'sd83443;
            15: v = 34'sd41722;
            16: v = 34'sd20861;
            17: v = 34'sd10430;
            18: v = 34'sd5215;
            19: v = 34'sd2608;
            20: v = 34'sd1304;
            21: v = 34'sd652;
            22: v = 34'sd326;
            23: v = 34'sd163;
            24: v = 34'sd81;
            25: v = 34'sd41;
            26: v = 34'sd20;
            27: v = 34'sd10;
            28: v = 34'sd5;
            29: v = 34'sd3;
            30: v = 34'sd1;
            31: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: sv/euler_to_quaternion.sv
`default_nettype none
// ---------------------------------------------------------------------------
// euler_to_quaternion
// Roll, pitch and yaw binary angles to a unit quaternion (ZYX order).
// ---------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   roll_angle, pitch_angle, yaw_angle
//  out      out_valid / out_stall quat_w, quat_x, quat_y, quat_z
//
//  One word per cycle sustained while the output is not stalled; out_valid
//  follows the input through the queue, the rotator load register,
//  32 rotator steps and 3 combine stages.
//  Reset clears the queue and all valid marks; data registers are not reset.
//  A stalled output freezes the whole back pipe; the 4-entry queue keeps
//  taking words until it fills.
module euler_to_quaternion (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [e2q_pkg::ANGLE_BITS-1:0] roll_angle,
    input  wire logic signed [e2q_pkg::ANGLE_BITS-1:0] pitch_angle,
    input  wire logic signed [e2q_pkg::ANGLE_BITS-1:0] yaw_angle,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [e2q_pkg::OUT_BITS-1:0]        quat_w,
    output logic signed [e2q_pkg::OUT_BITS-1:0]        quat_x,
    output logic signed [e2q_pkg::OUT_BITS-1:0]        quat_y,
    output logic signed [e2q_pkg::OUT_BITS-1:0]        quat_z
);

    logic                  q_valid;
    e2q_pkg::half_angles_t q_data;
    logic                  advance;
    logic                  trig_valid;
    e2q_pkg::trig_t        trig;

    // move the back pipe whenever the output word is free or taken
    assign advance = !out_valid || !out_stall;

    e2q_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (advance)
    );

    e2q_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .load_valid (q_valid),
        .load_data  (q_data),
        .trig_valid (trig_valid),
        .trig       (trig)
    );

    e2q_combine u_combine (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .trig_valid (trig_valid),
        .trig       (trig),
        .res_valid  (out_valid),
        .res_w      (quat_w),
        .res_x      (quat_x),
        .res_y      (quat_y),
        .res_z      (quat_z)
    );

endmodule
`default_nettype wire

// File: sv/e2q_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// e2q_front
// Accepts angle words, halves them into rotator angle units and holds them
// in a short queue ahead of the rotator pipeline.
// ---------------------------------------------------------------------------
module e2q_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [e2q_pkg::ANGLE_BITS-1:0] roll_angle,
    input  wire logic signed [e2q_pkg::ANGLE_BITS-1:0] pitch_angle,
    input  wire logic signed [e2q_pkg::ANGLE_BITS-1:0] yaw_angle,
    output logic                                     q_valid,
    output e2q_pkg::half_angles_t                    q_data,
    input  wire logic                                q_pop
);

    localparam int HALF_SHIFT = 32 - e2q_pkg::ANGLE_BITS;
    localparam int EXT_BITS   = e2q_pkg::Z_BITS - e2q_pkg::ANGLE_BITS;

    e2q_pkg::half_angles_t              entry_mem [e2q_pkg::QUEUE_DEPTH];
    e2q_pkg::half_angles_t              push_data;
    logic [e2q_pkg::QPTR_BITS-1:0]      wr_ptr_reg;
    logic [e2q_pkg::QPTR_BITS-1:0]      rd_ptr_reg;
    logic [e2q_pkg::QPTR_BITS:0]        count_reg;
    logic [e2q_pkg::QPTR_BITS:0]        count_next;
    logic                               push;
    logic                               pop;

    // scale each angle so that the half angle lands in 2^32-per-pi units
    assign push_data.roll  = {{EXT_BITS{roll_angle[e2q_pkg::ANGLE_BITS-1]}}, roll_angle}
                             <<< HALF_SHIFT;
    assign push_data.pitch = {{EXT_BITS{pitch_angle[e2q_pkg::ANGLE_BITS-1]}}, pitch_angle}
                             <<< HALF_SHIFT;
    assign push_data.yaw   = {{EXT_BITS{yaw_angle[e2q_pkg::ANGLE_BITS-1]}}, yaw_angle}
                             <<< HALF_SHIFT;

    assign in_stall = (count_reg == (e2q_pkg::QPTR_BITS+1)'(e2q_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_data   = entry_mem[rd_ptr_reg];

    // track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // store the word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (e2q_pkg::QPTR_BITS+1)'(e2q_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && count_reg == '0) |=> count_reg == $past(count_reg) + $past(push))
        else $error("pop from empty queue changed count");
`endif

endmodule
`default_nettype wire

// File: sv/e2q_cordic.sv
`default_nettype none
// ---------------------------------------------------------------------------
// e2q_cordic
// Three-lane pipelined rotator: one stage per iteration, giving cosine and
// sine of the roll, pitch and yaw half angles in Q30.
// ---------------------------------------------------------------------------
module e2q_cordic (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire logic                  load_valid,
    input  wire e2q_pkg::half_angles_t load_data,
    output logic                       trig_valid,
    output e2q_pkg::trig_t             trig
);

    localparam int NS = e2q_pkg::CORDIC_STEPS;
    localparam int ZB = e2q_pkg::Z_BITS;
    localparam int CB = e2q_pkg::C_BITS;

    logic signed [ZB-1:0] x_reg [NS+1][3];
    logic signed [ZB-1:0] y_reg [NS+1][3];
    logic signed [ZB-1:0] z_reg [NS+1][3];
    logic [NS:0]          valid_reg;

    // move valid marks down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NS-1:0], load_valid};
        end
    end

    // load the vector and rotate one step per stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < 3; l++)
            begin
                x_reg[0][l] <= e2q_pkg::CORDIC_GAIN;
                y_reg[0][l] <= '0;
            end
            z_reg[0][0] <= load_data.roll;
            z_reg[0][1] <= load_data.pitch;
            z_reg[0][2] <= load_data.yaw;
            for (int s = 0; s < NS; s++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (!z_reg[s][l][ZB-1])
                    begin
                        x_reg[s+1][l] <= x_reg[s][l] - (y_reg[s][l] >>> s);
                        y_reg[s+1][l] <= y_reg[s][l] + (x_reg[s][l] >>> s);
                        z_reg[s+1][l] <= z_reg[s][l] - e2q_pkg::atan_entry(s);
                    end
                    else
                    begin
                        x_reg[s+1][l] <= x_reg[s][l] + (y_reg[s][l] >>> s);
                        y_reg[s+1][l] <= y_reg[s][l] - (x_reg[s][l] >>> s);
                        z_reg[s+1][l] <= z_reg[s][l] + e2q_pkg::atan_entry(s);
                    end
                end
            end
        end
    end

    assign trig_valid  = valid_reg[NS];
    assign trig.cos_r  = x_reg[NS][0][CB-1:0];
    assign trig.sin_r  = y_reg[NS][0][CB-1:0];
    assign trig.cos_p  = x_reg[NS][1][CB-1:0];
    assign trig.sin_p  = y_reg[NS][1][CB-1:0];
    assign trig.cos_y  = x_reg[NS][2][CB-1:0];
    assign trig.sin_y  = y_reg[NS][2][CB-1:0];

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("rotator pipe moved while held");
`endif

endmodule
`default_nettype wire

// File: sv/e2q_combine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// e2q_combine
// Forms the pair products, the Q60 terms, and the rounded, saturated
// quaternion components in three registered stages.
// ---------------------------------------------------------------------------
module e2q_combine (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  advance,
    input  wire logic                                  trig_valid,
    input  wire e2q_pkg::trig_t                        trig,
    output logic                                       res_valid,
    output logic signed [e2q_pkg::OUT_BITS-1:0]        res_w,
    output logic signed [e2q_pkg::OUT_BITS-1:0]        res_x,
    output logic signed [e2q_pkg::OUT_BITS-1:0]        res_y,
    output logic signed [e2q_pkg::OUT_BITS-1:0]        res_z
);

    localparam int CB = e2q_pkg::C_BITS;
    localparam int PB = 2 * CB;
    localparam int SB = PB + 2;
    localparam int SH = 61 - e2q_pkg::OUT_BITS;
    localparam logic signed [SB-1:0] ROUND_ADD = SB'(1) <<< (SH - 1);
    localparam logic signed [SB-1:0] SAT_HI    = (SB'(1) <<< (e2q_pkg::OUT_BITS - 1)) - 1;
    localparam logic signed [SB-1:0] SAT_LO    = -SAT_HI - 1;

    logic signed [CB-1:0] crcp_reg, srsp_reg, srcp_reg, crsp_reg, cy_reg, sy_reg;
    logic signed [PB-1:0] t_reg [8];
    logic [2:0]           valid_reg;
    logic signed [e2q_pkg::OUT_BITS-1:0] w_reg, x_reg, y_reg, z_reg;

    // Q30 product with round half up
    function automatic logic signed [CB-1:0] mul_q30(input logic signed [CB-1:0] a,
                                                     input logic signed [CB-1:0] b);
        logic signed [PB-1:0] p;
        p = (PB'(a) * PB'(b)) + (PB'(1) <<< 29);
        return p[CB+29:30];
    endfunction

    // round Q60 sum to output format and clamp
    function automatic logic signed [e2q_pkg::OUT_BITS-1:0] to_out(
        input logic signed [PB-1:0] a, input logic signed [PB-1:0] b, input logic neg);
        logic signed [SB-1:0] s;
        logic signed [SB-1:0] v;
        s = neg ? (SB'(a) - SB'(b)) : (SB'(a) + SB'(b));
        v = (s + ROUND_ADD) >>> SH;
        if (v > SAT_HI)
        begin
            v = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            v = SAT_LO;
        end
        return v[e2q_pkg::OUT_BITS-1:0];
    endfunction

    // move valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[1:0], trig_valid};
        end
    end

    // pair products, terms, output rounding
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            crcp_reg <= mul_q30(trig.cos_r, trig.cos_p);
            srsp_reg <= mul_q30(trig.sin_r, trig.sin_p);
            srcp_reg <= mul_q30(trig.sin_r, trig.cos_p);
            crsp_reg <= mul_q30(trig.cos_r, trig.sin_p);
            cy_reg   <= trig.cos_y;
            sy_reg   <= trig.sin_y;

            t_reg[0] <= PB'(crcp_reg) * PB'(cy_reg);
            t_reg[1] <= PB'(srsp_reg) * PB'(sy_reg);
            t_reg[2] <= PB'(srcp_reg) * PB'(cy_reg);
            t_reg[3] <= PB'(crsp_reg) * PB'(sy_reg);
            t_reg[4] <= PB'(crsp_reg) * PB'(cy_reg);
            t_reg[5] <= PB'(srcp_reg) * PB'(sy_reg);
            t_reg[6] <= PB'(crcp_reg) * PB'(sy_reg);
            t_reg[7] <= PB'(srsp_reg) * PB'(cy_reg);

            w_reg <= to_out(t_reg[0], t_reg[1], 1'b0);
            x_reg <= to_out(t_reg[2], t_reg[3], 1'b1);
            y_reg <= to_out(t_reg[4], t_reg[5], 1'b0);
            z_reg <= to_out(t_reg[6], t_reg[7], 1'b1);
        end
    end

    assign res_valid = valid_reg[2];
    assign res_w     = w_reg;
    assign res_x     = x_reg;
    assign res_y     = y_reg;
    assign res_z     = z_reg;

`ifndef SYNTHESIS
    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(advance) && $past(advance, 2) && $past(advance, 3) && $past(trig_valid, 3))
        |-> res_valid)
        else $error("word lost in combine stages");
`endif

endmodule
`default_nettype wire

// File: test/tb_euler_to_quaternion.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_euler_to_quaternion
// Drives roll, pitch and yaw words into the quaternion block with random
// gaps and output stalls, predicts each quaternion with a bit-exact rotator
// model and compares the four components in arrival order.
// ---------------------------------------------------------------------------
module tb_euler_to_quaternion;

    localparam int ANGLE_BITS  = e2q_pkg::ANGLE_BITS;
    localparam int OUT_BITS    = e2q_pkg::OUT_BITS;
    localparam int LATENCY     = 40;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [OUT_BITS-1:0] w;
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] z;
    } quat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic out_valid;
    logic out_stall;
    logic signed [OUT_BITS-1:0] quat_w;
    logic signed [OUT_BITS-1:0] quat_x;
    logic signed [OUT_BITS-1:0] quat_y;
    logic signed [OUT_BITS-1:0] quat_z;

    quat_t pending_quats[$];
    int    error_count;
    int    cycle_count;

    euler_to_quaternion DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
        .out_valid(out_valid), .out_stall(out_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // arctan(2^-i) in units of pi / 2^32
    function automatic longint arctan_step(input int i);
        longint steps[32];
        steps = '{1073741824, 633866811, 334917815, 170009512, 85334662, 42708931,
                  21359677, 10680490, 5340327, 2670173, 1335088, 667544, 333772,
                  166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
                  163, 81, 41, 20, 10, 5, 3, 1, 1};
        return steps[i];
    endfunction

    // cosine and sine of half the angle, Q30
    task automatic half_angle_trig(input logic signed [ANGLE_BITS-1:0] angle,
                                   output longint c, output longint s);
        longint zr;
        longint xr;
        longint yr;
        longint dx;
        longint dy;
        zr = longint'(angle) * (longint'(1) << (32 - ANGLE_BITS));
        xr = 652032874;
        yr = 0;
        for (int i = 0; i < 32; i++)
        begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (zr >= 0)
            begin
                xr -= dx;
                yr += dy;
                zr -= arctan_step(i);
            end
            else
            begin
                xr += dx;
                yr -= dy;
                zr += arctan_step(i);
            end
        end
        c = xr;
        s = yr;
    endtask

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] round_q60(input longint v);
        longint r;
        r = (v + (longint'(1) << (60 - OUT_BITS))) >>> (61 - OUT_BITS);
        if (r > (longint'(1) << (OUT_BITS - 1)) - 1)
            r = (longint'(1) << (OUT_BITS - 1)) - 1;
        if (r < -(longint'(1) << (OUT_BITS - 1)))
            r = -(longint'(1) << (OUT_BITS - 1));
        return r[OUT_BITS-1:0];
    endfunction

    task automatic predict_quat(input logic signed [ANGLE_BITS-1:0] r,
                                input logic signed [ANGLE_BITS-1:0] p,
                                input logic signed [ANGLE_BITS-1:0] y);
        longint cr, sr, cp, sp, cy, sy;
        longint crcp, srsp, srcp, crsp;
        quat_t q;
        half_angle_trig(r, cr, sr);
        half_angle_trig(p, cp, sp);
        half_angle_trig(y, cy, sy);
        crcp = mul_q30(cr, cp);
        srsp = mul_q30(sr, sp);
        srcp = mul_q30(sr, cp);
        crsp = mul_q30(cr, sp);
        q.w = round_q60(crcp * cy + srsp * sy);
        q.x = round_q60(srcp * cy - crsp * sy);
        q.y = round_q60(crsp * cy + srcp * sy);
        q.z = round_q60(crcp * sy - srsp * cy);
        pending_quats = {pending_quats, q};
    endtask

    // send one angle word, after a random gap when gaps is set
    task automatic send_angles(input logic signed [ANGLE_BITS-1:0] r,
                               input logic signed [ANGLE_BITS-1:0] p,
                               input logic signed [ANGLE_BITS-1:0] y,
                               input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        roll_angle  <= r;
        pitch_angle <= p;
        yaw_angle   <= y;
        predict_quat(r, p, y);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_extremes();
        logic signed [ANGLE_BITS-1:0] corners[6];
        corners = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sh4000, -16'sh4000, 16'sh0001};
        // zero angles give w of one, saturated
        send_angles('0, '0, '0, 1'b0);
        for (int i = 1; i < 6; i++)
        begin
            send_angles(corners[i], '0, '0, 1'b0);
            send_angles('0, corners[i], '0, 1'b0);
            send_angles('0, '0, corners[i], 1'b0);
        end
        send_angles(-16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
        send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_angles(-16'sh0001, -16'sh0001, -16'sh0001, 1'b0);
        send_angles(16'sh5555, -16'sh2aab, 16'sh1234, 1'b0);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            // stretches with no gaps in every fourth block
            send_angles(ANGLE_BITS'($urandom), ANGLE_BITS'($urandom),
                        ANGLE_BITS'($urandom), ((i / 40) % 4) != 3);
        end
        in_valid <= 1'b0;
    endtask

    // randomize the output stall per result, with some unstalled stretches
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // check each accepted quaternion
    always @(posedge clk)
    begin
        quat_t q;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_quats.size() == 0)
            begin
                $display("%0t: unexpected quaternion %0d %0d %0d %0d",
                         $time, quat_w, quat_x, quat_y, quat_z);
                error_count++;
            end
            else
            begin
                q = pending_quats.pop_front();
                if (quat_w !== q.w)
                begin
                    $display("%0t: quat_w expected %0d actual %0d", $time, q.w, quat_w);
                    error_count++;
                end
                if (quat_x !== q.x)
                begin
                    $display("%0t: quat_x expected %0d actual %0d", $time, q.x, quat_x);
                    error_count++;
                end
                if (quat_y !== q.y)
                begin
                    $display("%0t: quat_y expected %0d actual %0d", $time, q.y, quat_y);
                    error_count++;
                end
                if (quat_z !== q.z)
                begin
                    $display("%0t: quat_z expected %0d actual %0d", $time, q.z, quat_z);
                    error_count++;
                end
            end
        end
    end

    // end the run on a hang
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        roll_angle  = '0;
        pitch_angle = '0;
        yaw_angle   = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_random(525);
        while (pending_quats.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
